### design/assert_macros.svh
// Assertion helpers used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/swsm_pkg.sv
package swsm_pkg;

	// Window storage
	localparam int FIFO_DEPTH  = 4096;
	localparam int SAMPLE_BITS = 14;
	localparam int PTR_W       = $clog2(FIFO_DEPTH);
	localparam int OCC_W       = $clog2(FIFO_DEPTH + 1);

	// Field widths
	localparam int TGT_W = 24;
	localparam int SUM_W = 25;
	localparam int CNT_W = 32;

	localparam logic [TGT_W-1:0] TGT_RESET = TGT_W'(1);
	localparam logic [CNT_W-1:0] CNT_MAX   = '1;

	// Result packing, lowest bit first
	localparam int OUT_MATCH_LSB = 0;
	localparam int OUT_CNT_LSB   = OUT_MATCH_LSB + 1;
	localparam int OUT_SUM_LSB   = OUT_CNT_LSB + CNT_W;
	localparam int OUT_LEN_LSB   = OUT_SUM_LSB + SUM_W;
	localparam int OUT_OVF_LSB   = OUT_LEN_LSB + OCC_W;
	localparam int OUT_RAW_W     = OUT_OVF_LSB + 1;
	localparam int M_TDATA_W     = ((OUT_RAW_W + 7) / 8) * 8;
	localparam int S_TDATA_W     = ((SAMPLE_BITS + 7) / 8) * 8;

	typedef logic [PTR_W-1:0]       ptr_t;
	typedef logic [OCC_W-1:0]       occ_t;
	typedef logic [SUM_W-1:0]       sum_t;
	typedef logic [SAMPLE_BITS-1:0] sample_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;  // take the input sample and push it
		logic pop;     // drop the oldest sample from the window
		logic finish;  // match check, count update, load result register
	} ctl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic trim_needed;  // sum above target with samples left
	} dp_status_t;

	// Circular pointer advance
	function automatic ptr_t ptr_next(input ptr_t p);
		ptr_t r;
		r = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
		return r;
	endfunction

endpackage

### design/swsm_ram.sv
module swsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port (read returns old data on collision)
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### design/swsm_ctrl.sv
module swsm_ctrl
	import swsm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	output logic       m_tvalid,
	input  logic       m_tready,
	input  dp_status_t status,
	output ctl_cmd_t   cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_TRIM
	} state_t;

	state_t state_q;
	logic   m_tvalid_q;
	logic   out_free;

	assign out_free = !m_tvalid_q || m_tready;

	// Commands to the datapath
	always_comb begin
		cmd        = '0;
		cmd.accept = (state_q == ST_IDLE) && s_tvalid;
		cmd.pop    = (state_q == ST_TRIM) && status.trim_needed;
		cmd.finish = (state_q == ST_TRIM) && !status.trim_needed && out_free;
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

	// State and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.accept) begin
						state_q <= ST_TRIM;
					end
				end
				ST_TRIM: begin
					if (cmd.finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### design/swsm_dp.sv
module swsm_dp
	import swsm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  ctl_cmd_t             cmd,
	output dp_status_t           status,
	input  sample_t              sample,
	input  logic                 new_run,
	input  logic                 cfg_we,
	input  logic [TGT_W-1:0]     cfg_wdata,
	output logic [M_TDATA_W-1:0] result
);

	ptr_t               rd_ptr_q, wr_ptr_q, rd_ptr_d;
	occ_t               occ_q;
	sum_t               sum_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [TGT_W-1:0]   tgt_q;
	logic               ovf_q;
	logic               fwd_q;
	sample_t            fwd_data_q;
	logic [M_TDATA_W-1:0] result_q;

	sample_t          ram_rdata, head;
	sum_t             head_ext, tgt_ext;
	ptr_t             base_rd, base_wr;
	occ_t             base_occ;
	sum_t             base_sum, acc_pop_sum, acc_sum, pop_sum;
	logic [CNT_W-1:0] base_cnt, cnt_next;
	logic             full, is_match;

	// Oldest sample, with forwarding of a write to the address being read
	assign head     = fwd_q ? fwd_data_q : ram_rdata;
	assign head_ext = SUM_W'(head);
	assign tgt_ext  = SUM_W'(tgt_q);

	assign status.trim_needed = (sum_q > tgt_ext) && (occ_q != '0);

	// Accept: optional clear, eviction when full, then push
	always_comb begin
		base_rd     = new_run ? '0 : rd_ptr_q;
		base_wr     = new_run ? '0 : wr_ptr_q;
		base_occ    = new_run ? '0 : occ_q;
		base_sum    = new_run ? '0 : sum_q;
		base_cnt    = new_run ? '0 : cnt_q;
		full        = !new_run && (occ_q == OCC_W'(FIFO_DEPTH));
		acc_pop_sum = full ? (base_sum - ((head_ext < base_sum) ? head_ext : base_sum))
		                   : base_sum;
		acc_sum     = acc_pop_sum + SUM_W'(sample);
	end

	// Trim step
	assign pop_sum = sum_q - ((head_ext < sum_q) ? head_ext : sum_q);

	// Finish: match check and saturating count
	assign is_match = (sum_q == tgt_ext);
	assign cnt_next = (is_match && (cnt_q != CNT_MAX)) ? cnt_q + CNT_W'(1) : cnt_q;

	// Next read pointer drives the memory so head tracks rd_ptr_q
	always_comb begin
		rd_ptr_d = rd_ptr_q;
		if (cmd.accept) begin
			rd_ptr_d = full ? ptr_next(base_rd) : base_rd;
		end else if (cmd.pop) begin
			rd_ptr_d = ptr_next(rd_ptr_q);
		end
	end

	swsm_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(FIFO_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (cmd.accept),
		.waddr(base_wr),
		.wdata(sample),
		.raddr(rd_ptr_d),
		.rdata(ram_rdata)
	);

	// Window state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			occ_q    <= '0;
			sum_q    <= '0;
			cnt_q    <= '0;
			tgt_q    <= TGT_RESET;
			ovf_q    <= 1'b0;
			fwd_q    <= 1'b0;
		end else begin
			rd_ptr_q <= rd_ptr_d;
			fwd_q    <= cmd.accept && (base_wr == rd_ptr_d);
			if (cfg_we) begin
				tgt_q <= cfg_wdata;
			end
			if (cmd.accept) begin
				wr_ptr_q <= ptr_next(base_wr);
				occ_q    <= full ? base_occ : base_occ + OCC_W'(1);
				sum_q    <= acc_sum;
				cnt_q    <= base_cnt;
				ovf_q    <= full;
			end else if (cmd.pop) begin
				occ_q <= occ_q - OCC_W'(1);
				sum_q <= pop_sum;
			end else if (cmd.finish) begin
				cnt_q <= cnt_next;
			end
		end
	end

	// Forwarded sample and result payload
	always_ff @(posedge clk) begin
		fwd_data_q <= sample;
		if (cmd.finish) begin
			result_q <= M_TDATA_W'({ovf_q, occ_q, sum_q, cnt_next, is_match});
		end
	end

	assign result = result_q;

endmodule

### design/streaming_window_sum_match_counter.sv
// Streaming window-sum match counter. Each sample transfer on the s_ side
// is pushed into a window FIFO of FIFO_DEPTH samples (oldest one evicted
// and overflow set when full), then the oldest samples are dropped while
// the window sum exceeds target_sum, and one result transfer follows on
// the m_ side. The trim loop pops one sample a cycle through the single
// read port of the sample memory, and each sample is popped at most once.
// The result sits in an output register, so the next sample is taken
// while it waits. The sample memory needs no clearing pass after reset.
// The user must write target_sum through cfg_we/cfg_wdata only while no
// sample is in flight; the block itself does not enforce this.
`include "assert_macros.svh"

module streaming_window_sum_match_counter
	import swsm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // sample
	input  logic                 s_tuser,   // new_run
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // is_match, match_total, window_sum,
	                                        // window_length, overflow
	input  logic                 cfg_we,
	input  logic [TGT_W-1:0]     cfg_wdata  // target_sum
);

	ctl_cmd_t   cmd;
	dp_status_t status;

	swsm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.status  (status),
		.cmd     (cmd)
	);

	swsm_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.sample   (s_tdata[SAMPLE_BITS-1:0]),
		.new_run  (s_tuser),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.result   (m_tdata)
	);

	// Result fields for checks
	logic             out_match;
	logic [CNT_W-1:0] out_cnt;
	sum_t             out_sum;
	occ_t             out_len;

	assign out_match = m_tdata[OUT_MATCH_LSB];
	assign out_cnt   = m_tdata[OUT_CNT_LSB +: CNT_W];
	assign out_sum   = m_tdata[OUT_SUM_LSB +: SUM_W];
	assign out_len   = m_tdata[OUT_LEN_LSB +: OCC_W];

	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready, "accepted sample did not leave idle")
	`ASSERT_IMPLIES(a_match_counted, clk, arst_n, m_tvalid && out_match, out_cnt != '0, "match flagged with zero total")
	`ASSERT_IMPLIES(a_len_bound, clk, arst_n, m_tvalid, out_len <= OCC_W'(FIFO_DEPTH), "window length beyond depth")
	`ASSERT_IMPLIES(a_empty_sum, clk, arst_n, m_tvalid && (out_len == '0), out_sum == '0, "empty window with nonzero sum")

endmodule

### sim/tb_streaming_window_sum_match_counter.sv
module tb_streaming_window_sum_match_counter;
	import swsm_pkg::*;

	localparam int SAMPLE_MAX    = (1 << SAMPLE_BITS) - 1;
	localparam int STALL_LIMIT   = 20000;
	localparam int SETTLE_CYCLES = 20;

	// One expected result transfer
	typedef struct {
		bit                 is_match;
		bit [CNT_W-1:0]     match_total;
		bit [SUM_W-1:0]     window_sum;
		bit [OCC_W-1:0]     window_length;
		bit                 overflow;
	} window_result_t;

	// Tracks the window, its sum and the match count; queues expected results
	class window_tracker;
		bit [SAMPLE_BITS-1:0] fifo_mem [FIFO_DEPTH];
		int unsigned          rd_ptr;
		int unsigned          wr_ptr;
		int unsigned          occupancy;
		longint unsigned      sum;
		bit [CNT_W-1:0]       match_count;
		longint unsigned      target;
		window_result_t       expected_windows [$];
		int unsigned          mismatches;

		function new();
			clear_run();
			target = TGT_RESET;
			mismatches = 0;
		endfunction

		function void clear_run();
			rd_ptr = 0;
			wr_ptr = 0;
			occupancy = 0;
			sum = 0;
			match_count = '0;
		endfunction

		function void set_target(logic [TGT_W-1:0] value);
			target = value;
		endfunction

		// Drop the oldest sample; the sum never goes below zero
		function void drop_oldest();
			longint unsigned v;
			v = fifo_mem[rd_ptr];
			sum -= (sum >= v) ? v : sum;
			rd_ptr = (rd_ptr == FIFO_DEPTH - 1) ? 0 : rd_ptr + 1;
			occupancy--;
		endfunction

		// Accepted sample transfer: push, trim, count, queue the result
		function void take_sample(logic [SAMPLE_BITS-1:0] value, bit new_run);
			window_result_t r;
			r.overflow = 1'b0;
			if (new_run)
				clear_run();
			if (occupancy >= FIFO_DEPTH) begin
				drop_oldest();
				r.overflow = 1'b1;
			end
			fifo_mem[wr_ptr] = value;
			wr_ptr = (wr_ptr == FIFO_DEPTH - 1) ? 0 : wr_ptr + 1;
			occupancy++;
			sum += value;
			while (sum > target && occupancy > 0)
				drop_oldest();
			r.is_match = (sum == target);
			if (r.is_match && match_count != CNT_MAX)
				match_count++;
			r.match_total = match_count;
			r.window_sum = sum[SUM_W-1:0];
			r.window_length = occupancy[OCC_W-1:0];
			expected_windows.push_back(r);
		endfunction

		function void compare_field(string name, longint unsigned want, logic [63:0] got);
			if (got !== 64'(want)) begin
				$error("%s mismatch: expected %0d, actual %0d", name, want, got);
				mismatches++;
			end
		endfunction

		// Accepted result transfer: compare against the oldest expectation
		function void check_result(logic [M_TDATA_W-1:0] d);
			window_result_t r;
			if (expected_windows.size() == 0) begin
				$error("result transfer with no sample pending: tdata %h", d);
				mismatches++;
				return;
			end
			r = expected_windows.pop_front();
			compare_field("is_match", r.is_match, 64'(d[OUT_MATCH_LSB]));
			compare_field("match_total", r.match_total, 64'(d[OUT_CNT_LSB +: CNT_W]));
			compare_field("window_sum", r.window_sum, 64'(d[OUT_SUM_LSB +: SUM_W]));
			compare_field("window_length", r.window_length, 64'(d[OUT_LEN_LSB +: OCC_W]));
			compare_field("overflow", r.overflow, 64'(d[OUT_OVF_LSB]));
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;    // sample
	logic                 s_tuser = 1'b0;  // new_run
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;         // is_match, match_total, window_sum,
	                                       // window_length, overflow
	logic                 cfg_we = 1'b0;
	logic [TGT_W-1:0]     cfg_wdata = '0;  // target_sum

	window_tracker board;
	int                    send_idle_pct = 0;
	int                    recv_stall_pct = 0;
	int unsigned           quiet_cycles = 0;

	streaming_window_sum_match_counter u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Result side backpressure
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_result(m_tdata);
	end

	// Watchdog: cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// Drive one sample transfer; entered and left at a falling edge
	task automatic send_sample(input int value, input bit new_run);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= S_TDATA_W'(value[SAMPLE_BITS-1:0]);
		s_tuser <= new_run;
		do @(posedge clk); while (s_tready !== 1'b1);
		board.take_sample(value[SAMPLE_BITS-1:0], new_run);
		@(negedge clk);
	endtask

	// Let every pending result drain, then let the block sit idle before returning
	task automatic drain();
		s_tvalid <= 1'b0;
		while (board.expected_windows.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_target(input int value);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= TGT_W'(value);
		@(negedge clk);
		cfg_we <= 1'b0;
		board.set_target(TGT_W'(value));
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	// Random traffic: runs of samples that add up to the target, mixed with noise
	task automatic run_phase(input int n_items, input int lo, input int hi,
	                         input int run_pct, input int new_run_pct);
		int count;
		int t;
		int kmin;
		int k;
		int rest;
		int left;
		int lo_p;
		int hi_p;
		int part;
		count = 0;
		t = int'(board.target);
		kmin = (t + SAMPLE_MAX - 1) / SAMPLE_MAX;
		while (count < n_items) begin
			if (t > 0 && kmin <= 8 && $urandom_range(99) < run_pct) begin
				k = $urandom_range((t < kmin + 5) ? t : kmin + 5, kmin);
				left = t;
				for (int i = 0; i < k; i++) begin
					rest = k - 1 - i;
					lo_p = (left > rest * SAMPLE_MAX) ? left - rest * SAMPLE_MAX : 1;
					hi_p = (left - rest < SAMPLE_MAX) ? left - rest : SAMPLE_MAX;
					part = (rest == 0) ? left : $urandom_range(hi_p, lo_p);
					left -= part;
					send_sample(part, (i == 0) && ($urandom_range(99) < 30));
					count++;
				end
			end else begin
				send_sample($urandom_range(hi, lo), $urandom_range(99) < new_run_pct);
				count++;
			end
		end
	endtask

	initial begin
		board = new();
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset target of one: single-sample matches, zero sample, full trim
		send_sample(1, 1'b0);
		send_sample(1, 1'b0);
		send_sample(0, 1'b0);
		send_sample(SAMPLE_MAX, 1'b0);
		send_sample(8192, 1'b1);
		send_sample(1, 1'b1);
		send_sample(0, 1'b0);

		// Zero target: trimming empties the window, empty window matches
		write_target(0);
		send_sample(0, 1'b0);
		send_sample(0, 1'b0);
		send_sample(5, 1'b0);
		send_sample(0, 1'b1);
		send_sample(16'h2aaa, 1'b0);

		// Largest target: window only grows
		write_target((1 << TGT_W) - 1);
		send_sample(SAMPLE_MAX, 1'b1);
		send_sample(16'h1555, 1'b0);
		send_sample(16'h2aaa, 1'b0);
		send_sample(SAMPLE_MAX, 1'b0);
		send_sample(1, 1'b0);
		send_sample(0, 1'b0);

		// Target just above the largest sample: multi-sample match, then trims
		write_target(SAMPLE_MAX + 1);
		send_sample(SAMPLE_MAX, 1'b1);
		send_sample(1, 1'b0);
		send_sample(SAMPLE_MAX, 1'b0);
		send_sample(2, 1'b0);

		// Random phases over several targets and idling patterns
		write_target(1000);
		set_idling(0, 0);
		run_phase(250, 1, 600, 50, 3);

		write_target(37);
		set_idling(66, 0);
		run_phase(200, 0, 40, 50, 3);

		write_target($urandom_range(120000, 20000));
		set_idling(0, 66);
		run_phase(250, 1, SAMPLE_MAX, 60, 3);

		write_target(0);
		set_idling(29, 29);
		run_phase(100, 0, 3, 0, 5);

		// Small samples under the largest target grow a long window
		write_target((1 << TGT_W) - 1);
		run_phase(700, 0, 4, 0, 0);

		// Small target after a long window: first sample trims nearly everything
		write_target(500);
		set_idling(0, 0);
		run_phase(200, 1, 200, 50, 2);

		write_target((1 << TGT_W) - 1);
		set_idling(0, 66);
		run_phase(150, 8192, SAMPLE_MAX, 0, 1);

		// Wind down
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.mismatches == 0 && board.expected_windows.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
